// ----- design/assert_macros.svh -----
// Assertion macros used by the controller core.
// Each macro expects signals clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- design/mpid_pkg.sv -----
// Shared types and constants of the multichannel PID controller.
// No dependencies; every design module imports this package.
package mpid_pkg;

	// Width of the shared multiply-accumulate register.
	localparam int unsigned ACC_W = 96;

	typedef enum logic [1:0] {
		CMD_STEP   = 2'd0,
		CMD_GAINS  = 2'd1,
		CMD_ENABLE = 2'd2,
		CMD_CLEAR  = 2'd3
	} mpid_cmd_t;

	typedef struct packed {
		mpid_cmd_t          cmd;
		logic [2:0]         channel;
		logic signed [31:0] target;
		logic signed [31:0] measured;
		logic signed [31:0] gain_p;
		logic signed [31:0] gain_i;
		logic signed [31:0] gain_d;
		logic               enable_in;
	} mpid_in_t;

	typedef struct packed {
		logic signed [31:0] drive;
		logic               enabled;
	} mpid_out_t;

	// Control of the shared multiply-accumulate unit.
	typedef struct packed {
		logic       go;   // operands valid this cycle
		logic       clr;  // clear the accumulator
		logic [2:0] sh;   // product weight in units of 16 bits
	} mpid_mac_ctl_t;

	// Control of the per-channel store.
	typedef struct packed {
		logic rd;
		logic gain_we;
		logic hist_we;
		logic hist_clr;
		logic en_we;
		logic en_val;
	} mpid_st_ctl_t;

endpackage

// ----- design/mpid_mac.sv -----
// Shared 33x17 signed multiplier with a shifted 96-bit accumulator.
// Depends on mpid_pkg.
module mpid_mac
	import mpid_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  mpid_mac_ctl_t      ctl,
	input  logic signed [32:0] a,
	input  logic signed [16:0] b,
	output logic [ACC_W-1:0]   acc
);

	logic signed [49:0] prod_s1;
	logic [2:0]         sh_s1;
	logic               vld_s1;
	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   prod_ext;
	logic [ACC_W-1:0]   prod_sh;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		sh_s1   <= ctl.sh;
	end

	assign prod_ext = {{(ACC_W-50){prod_s1[49]}}, prod_s1};

	always_comb begin
		case (sh_s1)
			3'd0: prod_sh = prod_ext;
			3'd1: prod_sh = prod_ext << 16;
			3'd2: prod_sh = prod_ext << 32;
			3'd3: prod_sh = prod_ext << 48;
			3'd4: prod_sh = prod_ext << 64;
			default: prod_sh = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= ctl.go;
			if (ctl.clr) begin
				acc_q <= '0;
			end else if (vld_s1) begin
				acc_q <= acc_q + prod_sh;
			end
		end
	end

	assign acc = acc_q;

endmodule

// ----- design/mpid_store.sv -----
// Per-channel gains, history and enable bits with registered reads.
// Depends on mpid_pkg; entries read as zero until written after reset.
module mpid_store
	import mpid_pkg::*;
#(
	parameter int unsigned CHANNELS = 8,
	localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  mpid_st_ctl_t       ctl,
	input  logic [CH_W-1:0]    rd_idx,
	input  logic [CH_W-1:0]    wr_idx,
	input  logic signed [31:0] gain_p_wr,
	input  logic signed [31:0] gain_i_wr,
	input  logic signed [31:0] gain_d_wr,
	input  logic signed [47:0] integ_wr,
	input  logic signed [32:0] prev_wr,
	output logic signed [31:0] gain_p,
	output logic signed [31:0] gain_i,
	output logic signed [31:0] gain_d,
	output logic signed [47:0] integ,
	output logic signed [32:0] prev_err,
	output logic               enable
);

	logic [31:0] p_mem    [CHANNELS];
	logic [31:0] i_mem    [CHANNELS];
	logic [31:0] d_mem    [CHANNELS];
	logic [47:0] int_mem  [CHANNELS];
	logic [32:0] prev_mem [CHANNELS];

	logic [CHANNELS-1:0] gval_q;
	logic [CHANNELS-1:0] hval_q;
	logic [CHANNELS-1:0] en_q;

	logic [31:0] rd_p_q, rd_i_q, rd_d_q;
	logic [47:0] rd_int_q;
	logic [32:0] rd_prev_q;
	logic        rd_gval_q, rd_hval_q, rd_en_q;

	always_ff @(posedge clk) begin
		if (ctl.gain_we) begin
			p_mem[wr_idx] <= gain_p_wr;
			i_mem[wr_idx] <= gain_i_wr;
			d_mem[wr_idx] <= gain_d_wr;
		end
		if (ctl.hist_we) begin
			int_mem[wr_idx]  <= integ_wr;
			prev_mem[wr_idx] <= prev_wr;
		end
		if (ctl.rd) begin
			rd_p_q    <= p_mem[rd_idx];
			rd_i_q    <= i_mem[rd_idx];
			rd_d_q    <= d_mem[rd_idx];
			rd_int_q  <= int_mem[rd_idx];
			rd_prev_q <= prev_mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gval_q    <= '0;
			hval_q    <= '0;
			en_q      <= '0;
			rd_gval_q <= 1'b0;
			rd_hval_q <= 1'b0;
			rd_en_q   <= 1'b0;
		end else begin
			if (ctl.gain_we) begin
				gval_q[wr_idx] <= 1'b1;
			end
			if (ctl.hist_we) begin
				hval_q[wr_idx] <= 1'b1;
			end else if (ctl.hist_clr) begin
				hval_q[wr_idx] <= 1'b0;
			end
			if (ctl.en_we) begin
				en_q[wr_idx] <= ctl.en_val;
			end
			if (ctl.rd) begin
				rd_gval_q <= gval_q[rd_idx];
				rd_hval_q <= hval_q[rd_idx];
				rd_en_q   <= en_q[rd_idx];
			end
		end
	end

	assign gain_p   = rd_gval_q ? rd_p_q : '0;
	assign gain_i   = rd_gval_q ? rd_i_q : '0;
	assign gain_d   = rd_gval_q ? rd_d_q : '0;
	assign integ    = rd_hval_q ? rd_int_q : '0;
	assign prev_err = rd_hval_q ? rd_prev_q : '0;
	assign enable   = rd_en_q;

endmodule

// ----- design/multichannel_pid_controller_core.sv -----
// Multichannel PID controller core: one word in, one word out, one word at a time.
// Control step on an enabled channel: the result is computed through one shared 33x17
// multiplier (6 products for the integral increment, 9 for the sum). Other commands and
// disabled channels skip the multiplier. A new word is taken in the cycle after the
// result loads; until then the input stalls, and a stalled output register holds it longer.
// Reset (arst_n low, asynchronous) zeroes all gains, histories and enable bits at once.
`include "assert_macros.svh"

module multichannel_pid_controller_core
	import mpid_pkg::*;
#(
	parameter int unsigned CHANNELS = 8
)
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  mpid_in_t  cmd_word,
	output logic      res_valid,
	input  logic      res_stall,
	output mpid_out_t res_word
);

	localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// floor(N/125) == (N * RECIP_M) >> QUOT_LSB for every N below 2^46.
	localparam logic [46:0] RECIP_M  = 47'd72057594037928;
	localparam int unsigned QUOT_LSB = 53;

	// Rounding offsets for a value with 48 fraction bits; the second also
	// completes the two's complement negate of a negative sum.
	localparam logic [ACC_W-1:0] RND_HALF    = ACC_W'(48'h8000_0000_0000);
	localparam logic [ACC_W-1:0] RND_HALF_P1 = ACC_W'(48'h8000_0000_0001);

	localparam logic [47:0] INT_MAX48 = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] INT_MIN48 = 48'h8000_0000_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_PREP,
		ST_MUL,
		ST_DWAIT,
		ST_INTEG,
		ST_PWAIT,
		ST_ROUND,
		ST_SAT,
		ST_FINISH
	} state_t;

	// Operand pairs fed to the multiplier, three 16-bit chunks each.
	typedef enum logic [2:0] {
		T_MLO,  // increment quotient, low reciprocal piece
		T_MHI,  // increment quotient, high reciprocal piece
		T_P,
		T_I,
		T_D
	} term_t;

	state_t state_q;
	term_t  term_q;
	logic [1:0] chunk_q;

	mpid_in_t  in_q;
	mpid_out_t res_q;
	logic      res_valid_q;

	logic signed [32:0] e_q;
	logic signed [33:0] dd_q;
	logic signed [43:0] ed_q;
	logic [45:0]        nmag_q;
	logic               eneg_q;
	logic signed [47:0] ei_q;
	logic [ACC_W-1:0]   magh_q;
	logic               sneg_q;
	logic signed [31:0] rdrive_q;
	logic               ren_q;

	// Channel decode: the field is three bits, the store index CH_W bits wide.
	logic [CH_W+2:0] rd_ext, wr_ext;
	logic [CH_W-1:0] rd_idx, wr_idx;
	logic            ch_ok;

	mpid_st_ctl_t       st_ctl;
	logic signed [31:0] st_gp, st_gi, st_gd;
	logic signed [47:0] st_int;
	logic signed [32:0] st_prev;
	logic               st_en;

	mpid_mac_ctl_t      mac_ctl;
	logic signed [32:0] mac_a;
	logic signed [16:0] mac_b;
	logic [ACC_W-1:0]   acc;

	logic               accept;
	logic               res_free;
	logic [32:0]        e_u;
	logic [32:0]        abs_e;
	logic [47:0]        vsel;
	logic [2:0]         sh_base;
	logic [39:0]        quot;
	logic [48:0]        inc49;
	logic [48:0]        ei49;
	logic [47:0]        ei_sat;
	logic [43:0]        dd44;
	logic               sum_neg;
	logic [47:0]        qm;
	logic [47:0]        qlim;
	logic [47:0]        qsat;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign res_free  = !res_valid_q || !res_stall;

	assign rd_ext = {{CH_W{1'b0}}, cmd_word.channel};
	assign wr_ext = {{CH_W{1'b0}}, in_q.channel};
	assign rd_idx = rd_ext[CH_W-1:0];
	assign wr_idx = wr_ext[CH_W-1:0];
	assign ch_ok  = (wr_ext < (CH_W+3)'(CHANNELS));

	// Store writes happen in DECODE for the plain commands and in INTEG for
	// the history update of a control step.
	always_comb begin
		st_ctl        = '0;
		st_ctl.rd     = accept;
		st_ctl.en_val = in_q.enable_in;
		if (state_q == ST_DECODE && ch_ok) begin
			case (in_q.cmd)
				CMD_STEP:   st_ctl.hist_clr = !st_en;
				CMD_GAINS:  st_ctl.gain_we  = 1'b1;
				CMD_ENABLE: st_ctl.en_we    = 1'b1;
				CMD_CLEAR:  st_ctl.hist_clr = 1'b1;
				default:    st_ctl.hist_clr = 1'b0;
			endcase
		end
		if (state_q == ST_INTEG) begin
			st_ctl.hist_we = 1'b1;
		end
	end

	mpid_store #(
		.CHANNELS (CHANNELS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (st_ctl),
		.rd_idx    (rd_idx),
		.wr_idx    (wr_idx),
		.gain_p_wr (in_q.gain_p),
		.gain_i_wr (in_q.gain_i),
		.gain_d_wr (in_q.gain_d),
		.integ_wr  (ei_sat),
		.prev_wr   (e_q),
		.gain_p    (st_gp),
		.gain_i    (st_gi),
		.gain_d    (st_gd),
		.integ     (st_int),
		.prev_err  (st_prev),
		.enable    (st_en)
	);

	// Magnitude of the error; the pattern of -2^32 reads back as 2^32 unsigned.
	assign e_u   = e_q;
	assign abs_e = e_q[32] ? (~e_u + 33'd1) : e_u;

	// Operand select for the shared multiplier. Each wide operand is taken
	// as two unsigned low chunks and a signed top chunk.
	always_comb begin
		case (term_q)
			T_MLO: begin
				mac_a   = {1'b0, RECIP_M[31:0]};
				vsel    = {2'b00, nmag_q};
				sh_base = 3'd0;
			end
			T_MHI: begin
				mac_a   = {18'd0, RECIP_M[46:32]};
				vsel    = {2'b00, nmag_q};
				sh_base = 3'd2;
			end
			T_P: begin
				mac_a   = {st_gp[31], st_gp};
				vsel    = {{15{e_q[32]}}, e_q};
				sh_base = 3'd1;
			end
			T_I: begin
				mac_a   = {st_gi[31], st_gi};
				vsel    = ei_q;
				sh_base = 3'd0;
			end
			T_D: begin
				mac_a   = {st_gd[31], st_gd};
				vsel    = {{4{ed_q[43]}}, ed_q};
				sh_base = 3'd1;
			end
			default: begin
				mac_a   = '0;
				vsel    = '0;
				sh_base = 3'd0;
			end
		endcase
		case (chunk_q)
			2'd0:    mac_b = {1'b0, vsel[15:0]};
			2'd1:    mac_b = {1'b0, vsel[31:16]};
			default: mac_b = {vsel[47], vsel[47:32]};
		endcase
		mac_ctl.go  = (state_q == ST_MUL);
		mac_ctl.clr = (state_q == ST_PREP) || (state_q == ST_INTEG);
		mac_ctl.sh  = sh_base + {1'b0, chunk_q};
	end

	mpid_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (mac_a),
		.b      (mac_b),
		.acc    (acc)
	);

	// Integral update: apply the sign to the rounded quotient, add, saturate
	// to 48 bits.
	assign quot  = acc[QUOT_LSB+39:QUOT_LSB];
	assign inc49 = eneg_q ? (~{9'd0, quot} + 49'd1) : {9'd0, quot};
	assign ei49  = {st_int[47], st_int} + inc49;
	always_comb begin
		if (ei49[48] != ei49[47]) begin
			ei_sat = ei49[48] ? INT_MIN48 : INT_MAX48;
		end else begin
			ei_sat = ei49[47:0];
		end
	end

	assign dd44 = {{10{dd_q[33]}}, dd_q};

	// Final rounding and saturation of the weighted sum.
	assign sum_neg = acc[ACC_W-1];
	assign qm      = magh_q[ACC_W-1:48];
	assign qlim    = sneg_q ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
	assign qsat    = (qm > qlim) ? qlim : qm;

	// Sequencer and result flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			term_q      <= T_MLO;
			chunk_q     <= 2'd0;
			res_valid_q <= 1'b0;
		end else begin
			// load a finished word, else drop the one just taken
			if (state_q == ST_FINISH && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (ch_ok && in_q.cmd == CMD_STEP && st_en) begin
						state_q <= ST_PREP;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_PREP: begin
					term_q  <= T_MLO;
					chunk_q <= 2'd0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (chunk_q == 2'd2) begin
						chunk_q <= 2'd0;
						case (term_q)
							T_MLO: term_q <= T_MHI;
							T_MHI: begin
								term_q  <= T_P;
								state_q <= ST_DWAIT;
							end
							T_P: term_q <= T_I;
							T_I: term_q <= T_D;
							default: state_q <= ST_PWAIT;
						endcase
					end else begin
						chunk_q <= chunk_q + 2'd1;
					end
				end
				ST_DWAIT: state_q <= ST_INTEG;
				ST_INTEG: state_q <= ST_MUL;
				ST_PWAIT: state_q <= ST_ROUND;
				ST_ROUND: state_q <= ST_SAT;
				ST_SAT:   state_q <= ST_FINISH;
				ST_FINISH: begin
					// hold the result until the output register is free
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= cmd_word;
		end
		case (state_q)
			ST_DECODE: begin
				e_q      <= {in_q.target[31], in_q.target} - {in_q.measured[31], in_q.measured};
				rdrive_q <= '0;
				if (!ch_ok) begin
					ren_q <= 1'b0;
				end else if (in_q.cmd == CMD_ENABLE) begin
					ren_q <= in_q.enable_in;
				end else begin
					ren_q <= st_en;
				end
			end
			ST_PREP: begin
				dd_q   <= {e_q[32], e_q} - {st_prev[32], st_prev};
				// |e| * 8192 + 62 over 125 equals |e| * 65536 + 500 over 1000
				nmag_q <= {abs_e, 13'd62};
				eneg_q <= e_q[32];
			end
			ST_DWAIT: begin
				// times 1000 as 1024 - 16 - 8
				ed_q <= (dd44 << 10) - (dd44 << 4) - (dd44 << 3);
			end
			ST_INTEG: begin
				ei_q <= ei_sat;
			end
			ST_ROUND: begin
				// fold negate and half-LSB offset into one add
				magh_q <= (sum_neg ? ~acc : acc) + (sum_neg ? RND_HALF_P1 : RND_HALF);
				sneg_q <= sum_neg;
			end
			ST_SAT: begin
				rdrive_q <= sneg_q ? (~qsat[31:0] + 32'd1) : qsat[31:0];
				ren_q    <= 1'b1;
			end
			ST_FINISH: begin
				if (res_free) begin
					res_q.drive   <= rdrive_q;
					res_q.enabled <= ren_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_q;

	// A taken word closes the input side in the next cycle.
	`ASSERT_NEXT(a_accept_closes, accept, cmd_stall, "input open right after accept")

	// A finished word lands in the output register once it is free.
	`ASSERT_NEXT(a_finish_loads, (state_q == ST_FINISH) && res_free,
		res_valid && (state_q == ST_IDLE), "finished word not loaded")

	// The increment quotient never reaches past its 40-bit field.
	`ASSERT_NOW(a_quot_fits, state_q == ST_INTEG, acc[ACC_W-1:QUOT_LSB+40] == '0,
		"increment quotient overflow")

endmodule
